@@ rtl/cell_shrink_to_polygons_top_defines.svh @@
// Assertion shorthands used by the checker file of this block.
`ifndef CELL_SHRINK_TO_POLYGONS_TOP_DEFINES_SVH
`define CELL_SHRINK_TO_POLYGONS_TOP_DEFINES_SVH

// Condition and consequence in the same cycle.
`define CSHR_ASSERT_NOW(lbl, clk, rst, pre, post, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error(msg);

// Consequence in the cycle after the condition.
`define CSHR_ASSERT_NEXT(lbl, clk, rst, pre, post, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error(msg);

`endif

@@ rtl/cshr_pkg.sv @@
`timescale 1ns / 1ps
package cshr_pkg;

   localparam int MAX_CORNERS   = 8;
   localparam int CORNER_SLOT_W = $clog2(MAX_CORNERS);
   localparam int BANKS         = 2;
   localparam int BUF_DEPTH     = BANKS * MAX_CORNERS;
   localparam int BUF_ADDR_W    = $clog2(BUF_DEPTH);
   localparam int CMD_DEPTH     = BANKS;
   localparam int CMD_PTR_W     = $clog2(CMD_DEPTH);

   localparam int HELD_W = 4;
   localparam logic [HELD_W-1:0] HELD_SAT = 4'd15;

   localparam int COORD_W  = 32;
   localparam int SUM_W    = COORD_W + CORNER_SLOT_W;
   localparam int FACTOR_W = 17;
   localparam int FRAC_W   = 16;
   localparam int PROD_W   = COORD_W + 1 + FACTOR_W + 1;
   localparam logic [FACTOR_W-1:0] FACTOR_ONE   = 17'd65536;
   localparam logic [FACTOR_W-1:0] FACTOR_RESET = 17'd32768;

   localparam int OUT_INDEX_W = 24;

   localparam int DIV_BITS_PER_CYCLE = 5;
   localparam int DIV_CYCLES         = SUM_W / DIV_BITS_PER_CYCLE;
   localparam int DIV_REM_W          = CORNER_SLOT_W;
   // partial dividend of one digit step: remainder above the next digit
   localparam int DIV_T_W            = DIV_REM_W + DIV_BITS_PER_CYCLE;
   // t * 410 / 2^11 equals t / 5 for every t below 2^8
   localparam int DIV_PROD_W         = DIV_T_W + 9;
   localparam logic [8:0] PYR_RECIP  = 9'd410;
   localparam int PYR_RECIP_SHIFT    = 11;

   localparam int FACE_SLOTS = 24;
   localparam int TET_SLOTS  = 12;
   localparam int PYR_SLOTS  = 16;
   localparam int FACE_CNT_W = $clog2(FACE_SLOTS);

   // cell kinds
   localparam logic [1:0] KIND_HEX = 2'd0;
   localparam logic [1:0] KIND_TET = 2'd1;
   localparam logic [1:0] KIND_PYR = 2'd2;
   localparam logic [1:0] KIND_BAD = 2'd3;

   // result record kinds
   localparam logic [1:0] REC_POINT = 2'd0;
   localparam logic [1:0] REC_FACE  = 2'd1;
   localparam logic [1:0] REC_ERROR = 2'd2;

   localparam logic [HELD_W-1:0] NEED_HEX = 4'd8;
   localparam logic [HELD_W-1:0] NEED_TET = 4'd4;
   localparam logic [HELD_W-1:0] NEED_PYR = 4'd5;

   localparam logic [CORNER_SLOT_W-1:0] HEX_FACE_TAB [FACE_SLOTS] = '{
      3'd0, 3'd3, 3'd2, 3'd1,  3'd4, 3'd5, 3'd6, 3'd7,  3'd0, 3'd4, 3'd7, 3'd3,
      3'd0, 3'd1, 3'd5, 3'd4,  3'd2, 3'd3, 3'd7, 3'd6,  3'd1, 3'd2, 3'd6, 3'd5
   };
   localparam logic [CORNER_SLOT_W-1:0] TET_FACE_TAB [TET_SLOTS] = '{
      3'd2, 3'd1, 3'd0,  3'd2, 3'd3, 3'd1,  3'd1, 3'd3, 3'd0,  3'd3, 3'd2, 3'd0
   };
   localparam logic [CORNER_SLOT_W-1:0] PYR_FACE_TAB [PYR_SLOTS] = '{
      3'd1, 3'd4, 3'd0,  3'd2, 3'd4, 3'd1,  3'd3, 3'd4, 3'd2,  3'd0, 3'd4, 3'd3,
      3'd0, 3'd3, 3'd2, 3'd1
   };
   // bit j set where slot j closes a face
   localparam logic [FACE_SLOTS-1:0] HEX_END_MASK = 24'h888888;
   localparam logic [TET_SLOTS-1:0]  TET_END_MASK = 12'h924;
   localparam logic [PYR_SLOTS-1:0]  PYR_END_MASK = 16'h8924;

   typedef struct packed {
      logic [1:0]                cell_kind;
      logic signed [COORD_W-1:0] corner_x;
      logic signed [COORD_W-1:0] corner_y;
      logic signed [COORD_W-1:0] corner_z;
      logic                      cell_end;
   } req_type;

   typedef struct packed {
      logic [1:0]                record_kind;
      logic signed [COORD_W-1:0] out_x;
      logic signed [COORD_W-1:0] out_y;
      logic signed [COORD_W-1:0] out_z;
      logic [OUT_INDEX_W-1:0]    point_index;
      logic                      face_end;
      logic                      run_last;
   } rsp_type;

   typedef struct packed {
      logic signed [COORD_W-1:0] x;
      logic signed [COORD_W-1:0] y;
      logic signed [COORD_W-1:0] z;
   } corner_type;

   typedef struct packed {
      logic signed [SUM_W-1:0] x;
      logic signed [SUM_W-1:0] y;
      logic signed [SUM_W-1:0] z;
   } sum_type;

   typedef struct packed {
      logic       ok;
      logic [1:0] kind;
      logic       bank;
      sum_type    sum;
   } cmd_type;

   typedef enum logic [2:0] {
      BK_IDLE,
      BK_ERROR,
      BK_DIV,
      BK_CENTER,
      BK_READ,
      BK_MUL,
      BK_POINT,
      BK_FACE
   } back_state_type;

   function automatic logic [HELD_W-1:0] cell_need(input logic [1:0] kind);
      logic [HELD_W-1:0] n;
      unique case (kind)
         KIND_HEX: n = NEED_HEX;
         KIND_TET: n = NEED_TET;
         KIND_PYR: n = NEED_PYR;
         KIND_BAD: n = '0;
      endcase
      return n;
   endfunction

   function automatic logic [FACE_CNT_W-1:0] face_total(input logic [1:0] kind);
      logic [FACE_CNT_W-1:0] n;
      unique case (kind)
         KIND_HEX: n = FACE_CNT_W'(FACE_SLOTS);
         KIND_TET: n = FACE_CNT_W'(TET_SLOTS);
         KIND_PYR: n = FACE_CNT_W'(PYR_SLOTS);
         KIND_BAD: n = '0;
      endcase
      return n;
   endfunction

   function automatic logic [CORNER_SLOT_W-1:0] face_corner(input logic [1:0] kind,
                                                         input logic [FACE_CNT_W-1:0] j);
      logic [CORNER_SLOT_W-1:0] c;
      unique case (kind)
         KIND_HEX: c = HEX_FACE_TAB[j];
         KIND_TET: c = TET_FACE_TAB[j[3:0]];
         KIND_PYR: c = PYR_FACE_TAB[j[3:0]];
         KIND_BAD: c = '0;
      endcase
      return c;
   endfunction

   function automatic logic face_last(input logic [1:0] kind,
                                      input logic [FACE_CNT_W-1:0] j);
      logic e;
      unique case (kind)
         KIND_HEX: e = HEX_END_MASK[j];
         KIND_TET: e = TET_END_MASK[j[3:0]];
         KIND_PYR: e = PYR_END_MASK[j[3:0]];
         KIND_BAD: e = 1'b0;
      endcase
      return e;
   endfunction

endpackage

@@ rtl/cshr_front.sv @@
`timescale 1ns / 1ps
module cshr_front
   import cshr_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  take,
   input  req_type               req,
   output logic                  cmd_push,
   output cmd_type               cmd,
   input  logic [BUF_ADDR_W-1:0] rd_addr,
   output corner_type            rd_data
);

   logic [HELD_W-1:0] held_ff, held_in;
   logic              bank_ff, bank_in;
   sum_type           sum_ff, sum_in, sum_add;
   logic [HELD_W-1:0] total;
   logic              store;
   corner_type        corner;
   corner_type        rd_data_ff;
   corner_type        mem [BUF_DEPTH];

   always_comb begin
      store  = take && (held_ff < HELD_W'(MAX_CORNERS));
      total  = (held_ff == HELD_SAT) ? HELD_SAT : held_ff + 4'd1;
      corner = '{x: req.corner_x, y: req.corner_y, z: req.corner_z};

      // only stored corners count toward the centroid
      sum_add.x = sum_ff.x + (store ? SUM_W'(req.corner_x) : {SUM_W{1'b0}});
      sum_add.y = sum_ff.y + (store ? SUM_W'(req.corner_y) : {SUM_W{1'b0}});
      sum_add.z = sum_ff.z + (store ? SUM_W'(req.corner_z) : {SUM_W{1'b0}});

      cmd.ok   = (req.cell_kind != KIND_BAD) && (total == cell_need(req.cell_kind));
      cmd.kind = req.cell_kind;
      cmd.bank = bank_ff;
      cmd.sum  = sum_add;

      held_in  = held_ff;
      bank_in  = bank_ff;
      sum_in   = sum_ff;
      cmd_push = 1'b0;
      if (take) begin
         if (req.cell_end) begin
            // close the cell and switch to the other bank
            cmd_push = 1'b1;
            held_in  = '0;
            bank_in  = !bank_ff;
            sum_in   = '0;
         end else begin
            held_in = total;
            sum_in  = sum_add;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         held_ff <= '0;
         bank_ff <= 1'b0;
         sum_ff  <= '0;
      end else begin
         held_ff <= held_in;
         bank_ff <= bank_in;
         sum_ff  <= sum_in;
      end
   end

   always_ff @(posedge clock) begin
      if (store) begin
         mem[{bank_ff, held_ff[CORNER_SLOT_W-1:0]}] <= corner;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

@@ rtl/cshr_cmd_fifo.sv @@
`timescale 1ns / 1ps
module cshr_cmd_fifo
   import cshr_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  cmd_type wdata,
   input  logic    pop,
   output cmd_type rdata,
   output logic    empty,
   output logic    full
);

   cmd_type                slot_ff [CMD_DEPTH];
   logic [CMD_PTR_W-1:0]   wr_ptr_ff, rd_ptr_ff;
   logic [CMD_PTR_W:0]     count_ff;
   logic                   do_push, do_pop;

   assign empty   = (count_ff == '0);
   assign full    = (count_ff == (CMD_PTR_W + 1)'(CMD_DEPTH));
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign rdata   = slot_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (do_pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
         if (do_push && !do_pop) begin
            count_ff <= count_ff + 1'b1;
         end else if (do_pop && !do_push) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= wdata;
      end
   end

endmodule

@@ rtl/cshr_back.sv @@
`timescale 1ns / 1ps
module cshr_back
   import cshr_pkg::*;
#(
   parameter int INDEX_WIDTH = 24
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_write,
   input  logic [FACTOR_W-1:0]   csr_value,
   input  logic                  cmd_empty,
   input  cmd_type               cmd,
   output logic                  cmd_pop,
   output logic [BUF_ADDR_W-1:0] rd_addr,
   input  corner_type            rd_data,
   input  logic                  pop,
   output logic                  empty,
   output rsp_type               rsp
);

   back_state_type          state_ff, state_in;
   logic [FACE_CNT_W-1:0]   step_ff, step_in;
   logic [SUM_W-1:0]        num_ff [3];
   logic [SUM_W-1:0]        num_in [3];
   logic [SUM_W-1:0]        div_num [3];
   logic [DIV_REM_W-1:0]    rem_ff [3];
   logic [DIV_REM_W-1:0]    rem_in [3];
   logic [DIV_REM_W-1:0]    div_rem [3];
   logic [2:0]              neg_ff, neg_in;
   logic signed [COORD_W-1:0] cen_ff [3];
   logic signed [COORD_W-1:0] cen_in [3];
   logic signed [PROD_W-1:0]  prod_ff [3];
   logic signed [PROD_W-1:0]  prod_in [3];
   logic signed [PROD_W-1:0]  prod_calc [3];
   logic signed [COORD_W-1:0] shrunk [3];
   logic signed [COORD_W-1:0] coord [3];
   logic signed [SUM_W-1:0]   sum_arr [3];
   logic [INDEX_WIDTH-1:0]  base_ff, base_in;
   logic [FACTOR_W-1:0]     factor_ff;
   logic [FACTOR_W-1:0]     factor_eff;
   rsp_type                 rsp_ff, rsp_in;
   rsp_type                 rec_point, rec_face, rec_err;
   logic                    full_ff, full_in;
   logic                    out_free;
   logic [HELD_W-1:0]       need;
   logic                    last_point, last_face;

   assign coord[0]   = rd_data.x;
   assign coord[1]   = rd_data.y;
   assign coord[2]   = rd_data.z;
   assign sum_arr[0] = cmd.sum.x;
   assign sum_arr[1] = cmd.sum.y;
   assign sum_arr[2] = cmd.sum.z;

   assign need       = cell_need(cmd.kind);
   assign factor_eff = (factor_ff > FACTOR_ONE) ? FACTOR_ONE : factor_ff;
   assign last_point = (step_ff == FACE_CNT_W'(need - 4'd1));
   assign last_face  = (step_ff == face_total(cmd.kind) - 1'b1);
   assign out_free   = !full_ff || pop;
   assign rd_addr    = {cmd.bank, step_ff[CORNER_SLOT_W-1:0]};

   // divide the corner sums by the corner count one digit per cycle:
   // shift for 8 and 4 corners, reciprocal multiply for 5
   always_comb begin
      logic [SUM_W-1:0]              n;
      logic [DIV_REM_W-1:0]          r;
      logic [DIV_T_W-1:0]            t;
      logic [DIV_BITS_PER_CYCLE-1:0] q;
      logic [DIV_PROD_W-1:0]         m;
      for (int c = 0; c < 3; c++) begin
         n = num_ff[c];
         t = {rem_ff[c], n[SUM_W-1 -: DIV_BITS_PER_CYCLE]};
         m = DIV_PROD_W'(t) * DIV_PROD_W'(PYR_RECIP);
         unique case (cmd.kind)
            KIND_HEX: begin
               q = t[DIV_T_W-1 -: DIV_BITS_PER_CYCLE];
               r = t[DIV_REM_W-1:0];
            end
            KIND_TET: begin
               q = t[DIV_T_W-2 -: DIV_BITS_PER_CYCLE];
               r = DIV_REM_W'(t[1:0]);
            end
            KIND_PYR: begin
               q = m[PYR_RECIP_SHIFT +: DIV_BITS_PER_CYCLE];
               r = DIV_REM_W'(t - DIV_T_W'(q) * DIV_T_W'(NEED_PYR));
            end
            KIND_BAD: begin
               q = '0;
               r = '0;
            end
         endcase
         div_num[c] = {n[SUM_W-DIV_BITS_PER_CYCLE-1:0], q};
         div_rem[c] = r;
      end
   end

   // scale distance from centroid, truncating toward zero
   always_comb begin
      logic signed [COORD_W:0]  diff;
      logic signed [FACTOR_W:0] fs;
      logic signed [PROD_W-1:0] adj;
      logic signed [PROD_W-1:0] quo;
      fs = $signed({1'b0, factor_eff});
      for (int c = 0; c < 3; c++) begin
         diff         = {coord[c][COORD_W-1], coord[c]} - {cen_ff[c][COORD_W-1], cen_ff[c]};
         prod_calc[c] = diff * fs;
         adj          = prod_ff[c] + (prod_ff[c][PROD_W-1] ?
                           PROD_W'((1 << FRAC_W) - 1) : {PROD_W{1'b0}});
         quo          = adj >>> FRAC_W;
         shrunk[c]    = cen_ff[c] + COORD_W'(quo);
      end
   end

   always_comb begin
      rec_point             = '0;
      rec_point.record_kind = REC_POINT;
      rec_point.out_x       = shrunk[0];
      rec_point.out_y       = shrunk[1];
      rec_point.out_z       = shrunk[2];
      rec_point.point_index = OUT_INDEX_W'(base_ff + INDEX_WIDTH'(step_ff));

      rec_face             = '0;
      rec_face.record_kind = REC_FACE;
      rec_face.point_index = OUT_INDEX_W'(base_ff + INDEX_WIDTH'(face_corner(cmd.kind, step_ff)));
      rec_face.face_end    = face_last(cmd.kind, step_ff);
      rec_face.run_last    = last_face;

      rec_err             = '0;
      rec_err.record_kind = REC_ERROR;
      rec_err.run_last    = 1'b1;
   end

   always_comb begin
      state_in = state_ff;
      step_in  = step_ff;
      num_in   = num_ff;
      rem_in   = rem_ff;
      neg_in   = neg_ff;
      cen_in   = cen_ff;
      prod_in  = prod_ff;
      base_in  = base_ff;
      rsp_in   = rsp_ff;
      full_in  = full_ff && !pop;
      cmd_pop  = 1'b0;

      unique case (state_ff)
         BK_IDLE: begin
            if (!cmd_empty) begin
               if (cmd.ok) begin
                  for (int c = 0; c < 3; c++) begin
                     neg_in[c] = sum_arr[c][SUM_W-1];
                     num_in[c] = sum_arr[c][SUM_W-1] ? -sum_arr[c] : sum_arr[c];
                     rem_in[c] = '0;
                  end
                  step_in  = '0;
                  state_in = BK_DIV;
               end else begin
                  state_in = BK_ERROR;
               end
            end
         end
         BK_ERROR: begin
            if (out_free) begin
               rsp_in   = rec_err;
               full_in  = 1'b1;
               cmd_pop  = 1'b1;
               state_in = BK_IDLE;
            end
         end
         BK_DIV: begin
            num_in  = div_num;
            rem_in  = div_rem;
            step_in = step_ff + 1'b1;
            if (step_ff == FACE_CNT_W'(DIV_CYCLES - 1)) begin
               state_in = BK_CENTER;
            end
         end
         BK_CENTER: begin
            for (int c = 0; c < 3; c++) begin
               cen_in[c] = neg_ff[c] ? COORD_W'(-num_ff[c]) : COORD_W'(num_ff[c]);
            end
            step_in  = '0;
            state_in = BK_READ;
         end
         BK_READ: begin
            state_in = BK_MUL;
         end
         BK_MUL: begin
            prod_in  = prod_calc;
            state_in = BK_POINT;
         end
         BK_POINT: begin
            if (out_free) begin
               rsp_in  = rec_point;
               full_in = 1'b1;
               if (last_point) begin
                  step_in  = '0;
                  state_in = BK_FACE;
               end else begin
                  step_in  = step_ff + 1'b1;
                  state_in = BK_READ;
               end
            end
         end
         BK_FACE: begin
            if (out_free) begin
               rsp_in  = rec_face;
               full_in = 1'b1;
               if (last_face) begin
                  // cell done: release its bank and advance the point base
                  cmd_pop  = 1'b1;
                  base_in  = base_ff + INDEX_WIDTH'(need);
                  step_in  = '0;
                  state_in = BK_IDLE;
               end else begin
                  step_in = step_ff + 1'b1;
               end
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= BK_IDLE;
         step_ff   <= '0;
         base_ff   <= '0;
         full_ff   <= 1'b0;
         factor_ff <= FACTOR_RESET;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
         base_ff  <= base_in;
         full_ff  <= full_in;
         if (csr_write) begin
            factor_ff <= csr_value;
         end
      end
   end

   always_ff @(posedge clock) begin
      num_ff  <= num_in;
      rem_ff  <= rem_in;
      neg_ff  <= neg_in;
      cen_ff  <= cen_in;
      prod_ff <= prod_in;
      rsp_ff  <= rsp_in;
   end

   assign empty = !full_ff;
   assign rsp   = rsp_ff;

endmodule

@@ rtl/cell_shrink_to_polygons_top.sv @@
`timescale 1ns / 1ps
// Cell shrink filter. Corners of hexahedra, tetrahedra and pyramids arrive one per request;
// the request with cell_end closes the cell, and the block then returns the cell's corners
// moved toward their centroid by csr_data (unsigned Q1.16, values above 1.0 act as 1.0),
// followed by the corner indices of its faces, or one error record for a bad cell. The
// front takes one request per cycle while full is low into one of two corner banks, so
// up to two closed cells wait for the back end; push stalls (full) while both banks are
// in use. For a good cell the back end dispatches the command, computes the centroid as
// seven 5-bit quotient digits by shift or reciprocal multiply and restores the sign, then
// gives each shrunk point by buffer read, multiply and round, and then each face index;
// a bad cell gives only its error record. Results leave through a single output
// register; each result waits there until popped, and the register can take the next
// result while the current one is popped. The corner buffer needs no clearing after
// reset. csr_data is written whenever csr_valid is high (csr_ready is always high) and
// must only change while the block is idle.
module cell_shrink_to_polygons_top
   import cshr_pkg::*;
#(
   parameter int INDEX_WIDTH = 24
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   output logic                full,
   input  req_type             req_data,
   output logic                empty,
   input  logic                pop,
   output rsp_type             rsp_data,
   input  logic                csr_valid,
   output logic                csr_ready,
   input  logic [FACTOR_W-1:0] csr_data
);

   logic                  take;
   logic                  cmd_push, cmd_pop, cmd_empty, cmd_full;
   cmd_type               cmd_wr, cmd_rd;
   logic [BUF_ADDR_W-1:0] rd_addr;
   corner_type            rd_data;

   assign csr_ready = 1'b1;
   assign full      = cmd_full;
   assign take      = push && !cmd_full;

   cshr_front u_front (
      .clock    (clock),
      .reset    (reset),
      .take     (take),
      .req      (req_data),
      .cmd_push (cmd_push),
      .cmd      (cmd_wr),
      .rd_addr  (rd_addr),
      .rd_data  (rd_data)
   );

   cshr_cmd_fifo u_cmd_fifo (
      .clock (clock),
      .reset (reset),
      .push  (cmd_push),
      .wdata (cmd_wr),
      .pop   (cmd_pop),
      .rdata (cmd_rd),
      .empty (cmd_empty),
      .full  (cmd_full)
   );

   cshr_back #(
      .INDEX_WIDTH (INDEX_WIDTH)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .csr_write (csr_valid && csr_ready),
      .csr_value (csr_data),
      .cmd_empty (cmd_empty),
      .cmd       (cmd_rd),
      .cmd_pop   (cmd_pop),
      .rd_addr   (rd_addr),
      .rd_data   (rd_data),
      .pop       (pop),
      .empty     (empty),
      .rsp       (rsp_data)
   );

endmodule

@@ rtl/cshr_checker.sv @@
`timescale 1ns / 1ps
`include "cell_shrink_to_polygons_top_defines.svh"
module cshr_checker
   import cshr_pkg::*;
(
   input logic    clock,
   input logic    reset,
   input logic    full,
   input logic    empty,
   input logic    pop,
   input rsp_type rsp_data
);

   `CSHR_ASSERT_NEXT(a_rsp_hold, clock, reset, !empty && !pop, !empty && $stable(rsp_data), "waiting result changed before pop")

   `CSHR_ASSERT_NOW(a_err_record, clock, reset, !empty && rsp_data.record_kind == REC_ERROR, rsp_data.run_last && !rsp_data.face_end && rsp_data.point_index == '0 && rsp_data.out_x == '0 && rsp_data.out_y == '0 && rsp_data.out_z == '0, "error record carries data")

   `CSHR_ASSERT_NOW(a_point_flags, clock, reset, !empty && rsp_data.record_kind == REC_POINT, !rsp_data.face_end && !rsp_data.run_last, "point record flagged as face end or last")

   `CSHR_ASSERT_NOW(a_face_coords, clock, reset, !empty && rsp_data.record_kind == REC_FACE, rsp_data.out_x == '0 && rsp_data.out_y == '0 && rsp_data.out_z == '0, "face record carries coordinates")

   `CSHR_ASSERT_NEXT(a_reset_clear, clock, 1'b0, reset, empty && !full, "block not drained after reset")

endmodule

bind cell_shrink_to_polygons_top cshr_checker u_checker (
   .clock    (clock),
   .reset    (reset),
   .full     (full),
   .empty    (empty),
   .pop      (pop),
   .rsp_data (rsp_data)
);
